[rtl/fxf_pkg.sv]
// Shared types, format codes and per-format constants for the fixed/float converter.
package fxf_pkg;

    localparam int DATA_W = 64;
    localparam int EXP_W  = 11;
    localparam int MANT_W = 52;
    localparam int EXP_BIAS = 1023;

    typedef logic [1:0]        t_fmt;
    typedef logic [DATA_W-1:0] t_word;

    localparam t_fmt FMT_Q4_12  = 2'd0;
    localparam t_fmt FMT_Q16_16 = 2'd1;
    localparam t_fmt FMT_Q24_8  = 2'd2;
    localparam t_fmt FMT_Q48_16 = 2'd3;

    localparam logic MODE_TO_DBL   = 1'b0;
    localparam logic MODE_FROM_DBL = 1'b1;

    // Fraction bits of each format.
    function automatic logic [4:0] frac_bits(input t_fmt fmt);
        logic [4:0] fb;
        case (fmt)
            FMT_Q4_12:  fb = 5'd12;
            FMT_Q16_16: fb = 5'd16;
            FMT_Q24_8:  fb = 5'd8;
            FMT_Q48_16: fb = 5'd16;
            default:    fb = 5'd16;
        endcase
        return fb;
    endfunction

    // Raw width minus one: position of the sign bit.
    function automatic logic [5:0] sign_pos(input t_fmt fmt);
        logic [5:0] p;
        case (fmt)
            FMT_Q4_12:  p = 6'd15;
            FMT_Q16_16: p = 6'd31;
            FMT_Q24_8:  p = 6'd31;
            FMT_Q48_16: p = 6'd63;
            default:    p = 6'd63;
        endcase
        return p;
    endfunction

    function automatic t_word max_raw(input t_fmt fmt);
        t_word m;
        case (fmt)
            FMT_Q4_12:  m = 64'h0000_0000_0000_7FFF;
            FMT_Q16_16: m = 64'h0000_0000_7FFF_FFFF;
            FMT_Q24_8:  m = 64'h0000_0000_7FFF_FFFF;
            FMT_Q48_16: m = 64'h7FFF_FFFF_FFFF_FFFF;
            default:    m = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic t_word min_raw(input t_fmt fmt);
        t_word m;
        case (fmt)
            FMT_Q4_12:  m = 64'hFFFF_FFFF_FFFF_8000;
            FMT_Q16_16: m = 64'hFFFF_FFFF_8000_0000;
            FMT_Q24_8:  m = 64'hFFFF_FFFF_8000_0000;
            FMT_Q48_16: m = 64'h8000_0000_0000_0000;
            default:    m = 64'h8000_0000_0000_0000;
        endcase
        return m;
    endfunction

endpackage

[rtl/fxf_to_dbl.sv]
// Fixed-point raw value to binary64, round to nearest even for wide magnitudes.
module fxf_to_dbl (
    input  fxf_pkg::t_fmt  i_fmt,
    input  fxf_pkg::t_word i_raw,
    output fxf_pkg::t_word o_dbl
);
    import fxf_pkg::*;

    t_word           x;
    logic            neg;
    t_word           mag;
    logic [5:0]      lz;
    t_word           norm;
    logic [MANT_W:0] mant_rnd;
    logic            guard;
    logic            sticky;
    logic            rnd_up;
    logic [11:0]     exp_v;

    always_comb begin
        case (i_fmt)
            FMT_Q4_12:  x = {{48{i_raw[15]}}, i_raw[15:0]};
            FMT_Q16_16: x = {{32{i_raw[31]}}, i_raw[31:0]};
            FMT_Q24_8:  x = {{32{i_raw[31]}}, i_raw[31:0]};
            default:    x = i_raw;
        endcase
    end

    assign neg = x[DATA_W-1];
    assign mag = neg ? (~x + 64'd1) : x;

    // Leading-zero count; highest set bit wins.
    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < DATA_W; i++) begin
            if (mag[i]) begin
                lz = 6'(DATA_W - 1 - i);
            end
        end
    end

    assign norm     = mag << lz;
    assign guard    = norm[10];
    assign sticky   = |norm[9:0];
    assign rnd_up   = guard & (sticky | norm[11]);
    assign mant_rnd = {1'b0, norm[62:11]} + {{MANT_W{1'b0}}, rnd_up};

    always_comb begin
        exp_v = 12'(EXP_BIAS + DATA_W - 1) - {6'd0, lz} - {7'd0, frac_bits(i_fmt)}
              + {11'd0, mant_rnd[MANT_W]};
        if (mag == '0) begin
            o_dbl = '0;
        end else begin
            o_dbl = {neg, exp_v[EXP_W-1:0], mant_rnd[MANT_W-1:0]};
        end
    end

endmodule

[rtl/fxf_from_dbl.sv]
// Binary64 to fixed-point raw value: truncate toward zero and clamp.
module fxf_from_dbl (
    input  fxf_pkg::t_fmt  i_fmt,
    input  fxf_pkg::t_word i_dbl,
    output fxf_pkg::t_word o_raw,
    output logic           o_sat
);
    import fxf_pkg::*;

    logic               sgn;
    logic [EXP_W-1:0]   e;
    logic [MANT_W-1:0]  fr;
    logic [MANT_W:0]    sig;
    logic signed [12:0] k;
    logic signed [12:0] wm1;
    logic [12:0]        sh_l;
    logic [12:0]        sh_r;
    t_word              mag;
    t_word              frac_mask;
    logic               frac_nz;
    logic               is_nan;

    assign sgn    = i_dbl[63];
    assign e      = i_dbl[62:52];
    assign fr     = i_dbl[51:0];
    assign sig    = {(e != '0), fr};
    assign is_nan = (e == '1) && (fr != '0);
    assign k      = $signed({2'b00, e}) + $signed({8'd0, frac_bits(i_fmt)})
                  - 13'sd1023;
    assign wm1    = $signed({7'd0, sign_pos(i_fmt)});
    assign sh_l   = 13'(k - 13'sd52);
    assign sh_r   = 13'(13'sd52 - k);

    always_comb begin
        if (k < 0) begin
            mag = '0;
        end else if (k >= 13'sd52) begin
            mag = {11'd0, sig} << sh_l[5:0];
        end else begin
            mag = {11'd0, sig} >> sh_r[5:0];
        end
    end

    // Fraction bits dropped by truncation: a value just above the maximum still clamps.
    assign frac_mask = ~({DATA_W{1'b1}} << sh_r[5:0]);
    assign frac_nz   = (k >= 0) && (k < 13'sd52) && (({11'd0, sig} & frac_mask) != '0);

    always_comb begin
        o_sat = 1'b0;
        o_raw = sgn ? (~mag + 64'd1) : mag;
        if (is_nan) begin
            o_sat = 1'b1;
            o_raw = '0;
        end else if (!sgn && (k >= wm1 || (mag == max_raw(i_fmt) && frac_nz))) begin
            o_sat = 1'b1;
            o_raw = max_raw(i_fmt);
        end else if (sgn && (k > wm1 || (k == wm1 && fr != '0))) begin
            o_sat = 1'b1;
            o_raw = min_raw(i_fmt);
        end else if (sgn && k == wm1) begin
            o_raw = min_raw(i_fmt);
        end
    end

endmodule

[rtl/fixed_float_converter.sv]
// Top level of the fixed-point / binary64 converter: input and result registers.
//
//  Channel   Direction  tdata                 tuser
//  s_axis    in         operand[63:0]         mode[0], format[2:1]
//  m_axis    out        result[63:0]          saturated[0]
//
// A request accepted into the input register passes the conversion logic and
// lands in the result register once the result stage advances.
// One request is taken every cycle while the output side keeps up; the rate is
// set by the two-stage register pipeline with no loop inside.
// Reset (synchronous, active low) clears both stage valid flags only.
// A stall on m_axis holds the result register, then the input register, and
// drops o_s_axis_tready only once both stages are full.
module fixed_float_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // operand[63:0]
    input  logic [2:0]  i_s_axis_tuser,   // mode[0], format[2:1]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // result[63:0]
    output logic [0:0]  o_m_axis_tuser    // saturated[0]
);
    import fxf_pkg::*;

    // Input stage
    logic  r_in_valid;
    logic  r_in_mode;
    t_fmt  r_in_fmt;
    t_word r_in_op;

    // Result stage
    logic  r_out_valid;
    logic  r_out_mode;
    t_word r_out_res;
    logic  r_out_sat;

    t_word to_dbl_res;
    t_word from_dbl_res;
    logic  from_dbl_sat;
    t_word n_out_res;
    logic  n_out_sat;
    logic  out_load;
    logic  in_load;

    // Advance the result stage when it is empty or being taken.
    assign out_load        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || out_load;
    assign in_load         = i_s_axis_tvalid && o_s_axis_tready;

    fxf_to_dbl u_to_dbl (
        .i_fmt (r_in_fmt),
        .i_raw (r_in_op),
        .o_dbl (to_dbl_res)
    );

    fxf_from_dbl u_from_dbl (
        .i_fmt (r_in_fmt),
        .i_dbl (r_in_op),
        .o_raw (from_dbl_res),
        .o_sat (from_dbl_sat)
    );

    // Pick the direction; fixed to double never saturates.
    assign n_out_res = (r_in_mode == MODE_FROM_DBL) ? from_dbl_res : to_dbl_res;
    assign n_out_sat = (r_in_mode == MODE_FROM_DBL) ? from_dbl_sat : 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_mode <= i_s_axis_tuser[0];
            r_in_fmt  <= i_s_axis_tuser[2:1];
            r_in_op   <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_out_mode <= r_in_mode;
            r_out_res  <= n_out_res;
            r_out_sat  <= n_out_sat;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_res;
    assign o_m_axis_tuser[0] = r_out_sat;

    // Saturation only arises in the double-to-fixed direction.
    a_sat_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |-> (r_out_mode == MODE_FROM_DBL))
        else $error("saturated flag set on a fixed-to-double result");

    // Input side stalls only when both stages are full and output is blocked.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid && !i_m_axis_tready))
        else $error("input stalled without a full pipeline");

    // A held input request moves into the result stage once it advances.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_load) |=> r_out_valid)
        else $error("input request lost between stages");

endmodule
